### rtl/vms_pkg.sv
// shared types, constants and helpers of the vector magnitude statistics unit
package vms_pkg;

   // field and storage widths
   localparam int SAMPLE_WIDTH = 32;
   localparam int COUNT_WIDTH  = 32;
   localparam int OUT_WIDTH    = 32;
   localparam int SUM_WIDTH    = 64;
   localparam int ROOT_WIDTH   = SUM_WIDTH / 2;
   localparam int FINITE_WIDTH = COUNT_WIDTH + 1;

   // shared compare-subtract width: covers the shifted divide remainder
   // and the shifted root remainder
   localparam int DIV_SUB_WIDTH  = FINITE_WIDTH + 1;
   localparam int ROOT_SUB_WIDTH = ROOT_WIDTH + 4;
   localparam int SUB_WIDTH      = (DIV_SUB_WIDTH > ROOT_SUB_WIDTH) ?
                                   DIV_SUB_WIDTH : ROOT_SUB_WIDTH;

   // iteration counts of the shared unit
   localparam int DIV_STEPS  = SUM_WIDTH;
   localparam int ROOT_STEPS = ROOT_WIDTH;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   // mean saturates at 2^31
   localparam logic [SUM_WIDTH-1:0] MEAN_MAX = SUM_WIDTH'(64'h8000_0000);

   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [OUT_WIDTH-1:0]    mag_type;
   typedef logic [SUM_WIDTH-1:0]    sum_type;
   typedef logic [FINITE_WIDTH-1:0] finite_type;

   // top level sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_CALC
   } vms_state_type;

   // shared divide / root unit sequencer
   typedef enum logic [1:0] {
      UN_IDLE,
      UN_DIV,
      UN_SQRT,
      UN_DONE
   } vms_unit_state_type;

   // operands handed to the shared unit
   typedef struct packed {
      sum_type    mag_sum;
      finite_type finite;
      sum_type    sq_sum;
   } vms_job_type;

   // handshake between top level and shared unit
   typedef struct packed {
      logic start;
      logic ack;
   } vms_ctrl_type;

   // results of the shared unit
   typedef struct packed {
      logic    done;
      mag_type mean;
      mag_type root;
   } vms_result_type;

   // clip a tally to the output field width
   function automatic mag_type clip_count(input count_type c);
      logic [63:0] w;
      w = 64'(c);
      clip_count = (w > 64'hFFFF_FFFF) ? '1 : w[OUT_WIDTH-1:0];
   endfunction

   // saturating unsigned add of two sums
   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic [SUM_WIDTH:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[SUM_WIDTH] ? '1 : s[SUM_WIDTH-1:0];
   endfunction

endpackage

### rtl/vector_magnitude_statistics_unit.sv
// top level of the vector magnitude statistics unit
//
// Elements enter on the req_ channel, one per item, as signed Q16.16 samples
// with an infinity flag; the item with req_last_element closes the vector.
// Each accepted element is folded into the running counts, extremes and
// magnitude sum as it is taken; its square goes through a registered
// multiplier and is added to the sum of squares in the next cycle, while no
// new element is taken. The closing element also starts the shared
// compare-subtract unit: a 64-step restoring divide for the mean, then a
// 32-step square root of the sum of squares. Its result is loaded into the
// rsp_ output register once the unit is done and that register is free; the
// next element can be taken after that.
// The output register parts the two channels: new elements are taken while
// a result waits on a stalled rsp_ side; only the next closing element waits
// for that register to free up. All statistics clear when the result is
// loaded, ready for the next vector.
// Synchronous reset returns every count and sum to its empty value and drops
// rsp_valid; no clearing pass is needed.
module vector_magnitude_statistics_unit import vms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample,
   input  logic        req_is_infinite,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_nonzero_count,
   output logic [31:0] rsp_infinite_count,
   output logic [31:0] rsp_zero_count,
   output logic [31:0] rsp_largest,
   output logic [31:0] rsp_smallest,
   output logic [31:0] rsp_mean_magnitude,
   output logic        rsp_mean_valid,
   output logic [31:0] rsp_l2_norm
);

   vms_state_type state_ff, state_in;

   count_type inf_tally_ff, inf_tally_in;
   count_type zero_tally_ff, zero_tally_in;
   count_type nz_tally_ff, nz_tally_in;
   mag_type   max_mag_ff, max_mag_in;
   mag_type   min_mag_ff, min_mag_in;
   sum_type   mag_sum_ff, mag_sum_in;
   sum_type   sq_sum_ff, sq_sum_in;
   sum_type   square_ff, square_in;
   logic      last_ff, last_in;

   logic      rsp_valid_ff, rsp_valid_in;
   mag_type   nz_out_ff, inf_out_ff, zero_out_ff;
   mag_type   largest_ff, smallest_ff, mean_ff, l2_ff;
   logic      mean_valid_ff;

   logic                    req_accept;
   logic                    rsp_free;
   logic                    capture;
   logic [SAMPLE_WIDTH-1:0] raw;
   logic                    is_zero;
   logic [SAMPLE_WIDTH-1:0] mag_raw;
   mag_type                 mag;
   finite_type              finite;
   logic                    any_nz;

   vms_ctrl_type   ctrl;
   vms_job_type    job;
   vms_result_type result;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // magnitude of the incoming sample, most negative value taken exactly
   assign raw     = req_sample[SAMPLE_WIDTH-1:0];
   assign is_zero = (raw == '0);
   assign mag_raw = raw[SAMPLE_WIDTH-1] ? (~raw + 1'b1) : raw;
   assign mag     = OUT_WIDTH'(mag_raw);

   assign finite = {1'b0, nz_tally_ff} + {1'b0, zero_tally_ff};
   assign any_nz = (nz_tally_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_accept) state_in = ST_ACCUM;
         ST_ACCUM: state_in = last_ff ? ST_CALC : ST_IDLE;
         ST_CALC:  if (result.done && rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl.start  = (state_ff == ST_ACCUM) && last_ff;
      ctrl.ack    = (state_ff == ST_CALC) && result.done && rsp_free;
      capture     = ctrl.ack;
      job.mag_sum = mag_sum_ff;
      job.finite  = finite;
      job.sq_sum  = sq_sum_in;
   end

   // running statistics
   always_comb begin
      inf_tally_in  = inf_tally_ff;
      zero_tally_in = zero_tally_ff;
      nz_tally_in   = nz_tally_ff;
      max_mag_in    = max_mag_ff;
      min_mag_in    = min_mag_ff;
      mag_sum_in    = mag_sum_ff;
      sq_sum_in     = sq_sum_ff;
      square_in     = square_ff;
      last_in       = last_ff;
      if (req_accept) begin
         last_in   = req_last_element;
         square_in = '0;
         if (req_is_infinite) begin
            if (inf_tally_ff != '1) inf_tally_in = inf_tally_ff + 1'b1;
         end else if (is_zero) begin
            if (zero_tally_ff != '1) zero_tally_in = zero_tally_ff + 1'b1;
         end else begin
            if (nz_tally_ff != '1) nz_tally_in = nz_tally_ff + 1'b1;
            if (mag > max_mag_ff) max_mag_in = mag;
            if (mag < min_mag_ff) min_mag_in = mag;
            mag_sum_in = sat_add(mag_sum_ff, SUM_WIDTH'(mag));
            square_in  = mag * mag;
         end
      end
      if (state_ff == ST_ACCUM) begin
         sq_sum_in = sat_add(sq_sum_ff, square_ff);
      end
      if (capture) begin
         inf_tally_in  = '0;
         zero_tally_in = '0;
         nz_tally_in   = '0;
         max_mag_in    = '0;
         min_mag_in    = '1;
         mag_sum_in    = '0;
         sq_sum_in     = '0;
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (capture) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         inf_tally_ff  <= '0;
         zero_tally_ff <= '0;
         nz_tally_ff   <= '0;
         max_mag_ff    <= '0;
         min_mag_ff    <= '1;
         mag_sum_ff    <= '0;
         sq_sum_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         inf_tally_ff  <= inf_tally_in;
         zero_tally_ff <= zero_tally_in;
         nz_tally_ff   <= nz_tally_in;
         max_mag_ff    <= max_mag_in;
         min_mag_ff    <= min_mag_in;
         mag_sum_ff    <= mag_sum_in;
         sq_sum_ff     <= sq_sum_in;
      end
      square_ff <= square_in;
      last_ff   <= last_in;
   end

   // result payload, loaded when the shared unit has finished and the output register is free
   always_ff @(posedge clock) begin
      if (capture) begin
         nz_out_ff     <= clip_count(nz_tally_ff);
         inf_out_ff    <= clip_count(inf_tally_ff);
         zero_out_ff   <= clip_count(zero_tally_ff);
         largest_ff    <= any_nz ? max_mag_ff : '0;
         smallest_ff   <= any_nz ? min_mag_ff : '0;
         mean_ff       <= (finite != '0) ? result.mean : '0;
         mean_valid_ff <= (finite != '0);
         l2_ff         <= result.root;
      end
   end

   vms_iter_unit u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .job    (job),
      .result (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_nonzero_count  = nz_out_ff;
   assign rsp_infinite_count = inf_out_ff;
   assign rsp_zero_count     = zero_out_ff;
   assign rsp_largest        = largest_ff;
   assign rsp_smallest       = smallest_ff;
   assign rsp_mean_magnitude = mean_ff;
   assign rsp_mean_valid     = mean_valid_ff;
   assign rsp_l2_norm        = l2_ff;

endmodule

### rtl/vms_iter_unit.sv
// shared compare-subtract unit: restoring divide for the mean, then square root
module vms_iter_unit import vms_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  vms_ctrl_type   ctrl,
   input  vms_job_type    job,
   output vms_result_type result
);

   vms_unit_state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [SUB_WIDTH-1:0]  rem_ff, rem_in;
   sum_type               quot_ff, quot_in;
   finite_type            divisor_ff, divisor_in;
   sum_type               rad_ff, rad_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;

   logic [SUB_WIDTH-1:0]  op_a;
   logic [SUB_WIDTH-1:0]  op_b;
   logic [SUB_WIDTH:0]    diff;
   logic                  ge;
   logic                  last_step;

   // shared compare-subtract
   assign diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = !diff[SUB_WIDTH];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         UN_IDLE: if (ctrl.start) state_in = UN_DIV;
         UN_DIV:  if (last_step) state_in = UN_SQRT;
         UN_SQRT: if (last_step) state_in = UN_DONE;
         UN_DONE: if (ctrl.ack) state_in = UN_IDLE;
         default: state_in = UN_IDLE;
      endcase
   end

   // operand selection and step limit
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      last_step = 1'b0;
      case (state_ff)
         UN_DIV: begin
            op_a      = {rem_ff[SUB_WIDTH-2:0], quot_ff[SUM_WIDTH-1]};
            op_b      = SUB_WIDTH'(divisor_ff);
            last_step = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));
         end
         UN_SQRT: begin
            op_a      = {rem_ff[SUB_WIDTH-3:0], rad_ff[SUM_WIDTH-1 -: 2]};
            op_b      = SUB_WIDTH'({root_ff, 2'b01});
            last_step = (step_ff == STEP_WIDTH'(ROOT_STEPS - 1));
         end
         default: begin
            op_a      = '0;
            op_b      = '0;
            last_step = 1'b0;
         end
      endcase
   end

   // datapath update
   always_comb begin
      step_in    = step_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      case (state_ff)
         UN_IDLE: begin
            if (ctrl.start) begin
               step_in    = '0;
               rem_in     = '0;
               quot_in    = job.mag_sum;
               divisor_in = job.finite;
               rad_in     = job.sq_sum;
               root_in    = '0;
            end
         end
         UN_DIV: begin
            // quotient bits shift in as dividend bits shift out
            rem_in  = ge ? diff[SUB_WIDTH-1:0] : op_a;
            quot_in = {quot_ff[SUM_WIDTH-2:0], ge};
            step_in = step_ff + 1'b1;
            if (last_step) begin
               rem_in  = '0;
               step_in = '0;
            end
         end
         UN_SQRT: begin
            rem_in  = ge ? diff[SUB_WIDTH-1:0] : op_a;
            root_in = {root_ff[ROOT_WIDTH-2:0], ge};
            rad_in  = {rad_ff[SUM_WIDTH-3:0], 2'b00};
            step_in = step_ff + 1'b1;
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= UN_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
      rad_ff     <= rad_in;
      root_ff    <= root_in;
   end

   // results, mean clipped to its range
   always_comb begin
      result.done = (state_ff == UN_DONE);
      result.mean = (quot_ff > MEAN_MAX) ? OUT_WIDTH'(MEAN_MAX) : quot_ff[OUT_WIDTH-1:0];
      result.root = OUT_WIDTH'(root_ff);
   end

endmodule

### rtl/vms_checker.sv
// port-level checker of the vector magnitude statistics unit and its binding
module vms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_nonzero_count,
   input logic [31:0] rsp_zero_count,
   input logic [31:0] rsp_largest,
   input logic [31:0] rsp_smallest,
   input logic [31:0] rsp_mean_magnitude,
   input logic        rsp_mean_valid
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // each accepted item is folded in before the next is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken during accumulation");

   // extremes only when a finite nonzero element was seen
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nonzero_count == 32'd0 |->
         rsp_largest == 32'd0 && rsp_smallest == 32'd0)
      else $error("extremes reported for empty vector");

   // undefined mean means no finite element and a zero mean field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mean_valid |->
         rsp_mean_magnitude == 32'd0 && rsp_nonzero_count == 32'd0 &&
         rsp_zero_count == 32'd0)
      else $error("mean flag inconsistent with counts");

endmodule

bind vector_magnitude_statistics_unit vms_checker u_vms_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_nonzero_count  (rsp_nonzero_count),
   .rsp_zero_count     (rsp_zero_count),
   .rsp_largest        (rsp_largest),
   .rsp_smallest       (rsp_smallest),
   .rsp_mean_magnitude (rsp_mean_magnitude),
   .rsp_mean_valid     (rsp_mean_valid)
);
